// ===== rtl/stip_pkg.sv =====
package stip_pkg;

	// widths of the result fields
	localparam int VALUE_BITS  = 32;
	localparam int COUNT_BITS  = 16;
	localparam int BASE_BITS   = 6;
	localparam int CHAR_BITS   = 8;
	localparam int STATUS_BITS = 2;
	localparam int MAX_BASE    = 36;

	// command queue between front and back
	localparam int CMD_DEPTH    = 4;
	localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

	// result queue at the output
	localparam int RES_DEPTH    = 2;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

	localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] BASE_UNARY = BASE_BITS'(1);
	localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
	localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
	localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);
	localparam logic [BASE_BITS-1:0] BASE_TOP   = BASE_BITS'(MAX_BASE);
	localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_DEC;

	// digit value of a byte that is no alphanumeric, above every legal base
	localparam logic [BASE_BITS-1:0] DIGIT_NONE   = '1;
	localparam logic [BASE_BITS-1:0] ALPHA_OFFSET = BASE_BITS'(10);

	localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
	localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [CHAR_BITS-1:0] CH_LOW_A  = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_LOW_X  = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_LOW_Z  = 8'h7A;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_BAD_BASE = 2'd2
	} status_t;

	// classified character, as the front hands it to the back
	typedef struct packed {
		logic                 start;
		logic                 space;
		logic                 minus;
		logic                 plus;
		logic                 zero;
		logic                 hex_mark;
		logic [BASE_BITS-1:0] digit;
	} cmd_t;

	// largest magnitude, the most negative value
	localparam logic [VALUE_BITS-1:0] MAX_MAG = VALUE_BITS'(1) << (VALUE_BITS - 1);

	// per-base limit: a magnitude above it overflows when multiplied
	localparam logic [VALUE_BITS-1:0] THRESH_TABLE [MAX_BASE+1] = '{
		MAX_MAG, MAX_MAG,
		VALUE_BITS'(MAX_MAG / 2),  VALUE_BITS'(MAX_MAG / 3),  VALUE_BITS'(MAX_MAG / 4),
		VALUE_BITS'(MAX_MAG / 5),  VALUE_BITS'(MAX_MAG / 6),  VALUE_BITS'(MAX_MAG / 7),
		VALUE_BITS'(MAX_MAG / 8),  VALUE_BITS'(MAX_MAG / 9),  VALUE_BITS'(MAX_MAG / 10),
		VALUE_BITS'(MAX_MAG / 11), VALUE_BITS'(MAX_MAG / 12), VALUE_BITS'(MAX_MAG / 13),
		VALUE_BITS'(MAX_MAG / 14), VALUE_BITS'(MAX_MAG / 15), VALUE_BITS'(MAX_MAG / 16),
		VALUE_BITS'(MAX_MAG / 17), VALUE_BITS'(MAX_MAG / 18), VALUE_BITS'(MAX_MAG / 19),
		VALUE_BITS'(MAX_MAG / 20), VALUE_BITS'(MAX_MAG / 21), VALUE_BITS'(MAX_MAG / 22),
		VALUE_BITS'(MAX_MAG / 23), VALUE_BITS'(MAX_MAG / 24), VALUE_BITS'(MAX_MAG / 25),
		VALUE_BITS'(MAX_MAG / 26), VALUE_BITS'(MAX_MAG / 27), VALUE_BITS'(MAX_MAG / 28),
		VALUE_BITS'(MAX_MAG / 29), VALUE_BITS'(MAX_MAG / 30), VALUE_BITS'(MAX_MAG / 31),
		VALUE_BITS'(MAX_MAG / 32), VALUE_BITS'(MAX_MAG / 33), VALUE_BITS'(MAX_MAG / 34),
		VALUE_BITS'(MAX_MAG / 35), VALUE_BITS'(MAX_MAG / 36)
	};

endpackage

// ===== rtl/string_to_integer_parser.sv =====
// streaming strtol-style parser: one byte is pushed per request, and a request with
// start_flag high begins a new string with that byte. leading whitespace and one sign
// are skipped, a 0x/0X prefix is recognized for base 0 and 16, a leading zero picks
// octal for base 0, and digits below the base accumulate into a 32-bit magnitude that
// saturates to the minimum or maximum on overflow. the first byte that is not a digit
// ends the string and produces one result request (value, bytes consumed, status); a
// start with an invalid base reports status 2 at once. a new byte is taken every cycle
// while the four-deep command queue has room, so the sustained rate is one byte per
// clock while the result queue has room; the back end does its base multiply and
// threshold compare combinationally. a result passes through the command queue and waits in a
// two-deep result queue, so pushing goes on while pop is held off.
// number_base is latched at each start; write it only while no string is in flight.
module string_to_integer_parser import stip_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic        [BASE_BITS-1:0]   number_base,
	// input byte queue side
	input  logic                          push,
	output logic                          full,
	input  logic                          start_flag,
	input  logic        [CHAR_BITS-1:0]   char_code,
	// result queue side
	output logic                          empty,
	input  logic                          pop,
	output logic signed [VALUE_BITS-1:0]  parsed_value,
	output logic        [COUNT_BITS-1:0]  consumed_count,
	output logic        [STATUS_BITS-1:0] parse_status
);

	logic [BASE_BITS-1:0] base_q;

	logic                 wr_en;
	cmd_t                 wr_cmd;
	logic                 cmd_valid;
	logic                 cmd_take;
	cmd_t                 cmd;

	// base register, always ready for a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= number_base;
		end
	end

	// front end: takes the byte and classifies it
	stip_front u_front (
		.push       (push),
		.full       (full),
		.start_flag (start_flag),
		.char_code  (char_code),
		.wr_en      (wr_en),
		.wr_cmd     (wr_cmd)
	);

	// short queue decoupling front and back
	stip_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_cmd   (wr_cmd),
		.full     (full),
		.rd_en    (cmd_take),
		.rd_valid (cmd_valid),
		.rd_cmd   (cmd)
	);

	// back end: parse state, accumulate, result queue
	stip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_base   (base_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take),
		.empty      (empty),
		.pop        (pop),
		.res_value  (parsed_value),
		.res_count  (consumed_count),
		.res_status (parse_status)
	);

endmodule

// ===== rtl/stip_front.sv =====
module stip_front import stip_pkg::*; (
	input  logic                 push,
	input  logic                 full,
	input  logic                 start_flag,
	input  logic [CHAR_BITS-1:0] char_code,
	output logic                 wr_en,
	output cmd_t                 wr_cmd
);

	logic [BASE_BITS-1:0] digit;

	assign wr_en = push && !full;

	// alphanumeric digit value
	always_comb begin
		unique case (char_code) inside
			[CH_ZERO:CH_NINE]:   digit = BASE_BITS'(char_code - CH_ZERO);
			[CH_UP_A:CH_UP_Z]:   digit = BASE_BITS'(char_code - CH_UP_A) + ALPHA_OFFSET;
			[CH_LOW_A:CH_LOW_Z]: digit = BASE_BITS'(char_code - CH_LOW_A) + ALPHA_OFFSET;
			default:             digit = DIGIT_NONE;
		endcase
	end

	always_comb begin
		wr_cmd.start    = start_flag;
		wr_cmd.space    = (char_code >= CH_TAB && char_code <= CH_CR) || char_code == CH_SPACE;
		wr_cmd.minus    = char_code == CH_MINUS;
		wr_cmd.plus     = char_code == CH_PLUS;
		wr_cmd.zero     = char_code == CH_ZERO;
		wr_cmd.hex_mark = char_code == CH_LOW_X || char_code == CH_UP_X;
		wr_cmd.digit    = digit;
	end

endmodule

// ===== rtl/stip_queue.sv =====
module stip_queue import stip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	cmd_t                    entry_q [CMD_DEPTH];
	logic [CMD_PTR_BITS-1:0] wr_ptr_q;
	logic [CMD_PTR_BITS-1:0] rd_ptr_q;
	logic [CMD_CNT_BITS-1:0] cnt_q;

	assign full     = cnt_q == CMD_CNT_BITS'(CMD_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("command queue fill count lost a write");

endmodule

// ===== rtl/stip_back.sv =====
module stip_back import stip_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [BASE_BITS-1:0]          cfg_base,
	input  logic                          cmd_valid,
	input  cmd_t                          cmd,
	output logic                          cmd_take,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [VALUE_BITS-1:0]  res_value,
	output logic        [COUNT_BITS-1:0]  res_count,
	output logic        [STATUS_BITS-1:0] res_status
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_LEAD   = 4'b0010,
		PH_ZERO   = 4'b0100,
		PH_DIGITS = 4'b1000
	} phase_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic        [COUNT_BITS-1:0] count;
		status_t                      status;
	} res_t;

	localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

	phase_t                  phase_q, phase_d;
	logic                    neg_q, neg_d;
	logic [BASE_BITS-1:0]    base_q, base_d;
	logic [VALUE_BITS-1:0]   mag_q, mag_d;
	logic                    ovf_q, ovf_d;
	logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
	logic                    pend_q, pend_d;

	res_t                    res_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] res_wr_ptr_q;
	logic [RES_PTR_BITS-1:0] res_rd_ptr_q;
	logic [RES_CNT_BITS-1:0] res_cnt_q;

	logic                    base_bad;
	logic                    pop_ok;
	logic                    room;
	logic                    emit;
	logic                    res_wr;
	res_t                    res_d;

	logic                    done;
	logic                    over;
	logic [VALUE_BITS-1:0]   thresh;
	logic [PROD_BITS-1:0]    prod;
	logic [VALUE_BITS:0]     sum;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	assign base_bad = cfg_base == BASE_UNARY || cfg_base > BASE_TOP;
	assign empty    = res_cnt_q == '0;
	assign pop_ok   = pop && !empty;
	assign room     = (res_cnt_q != RES_CNT_BITS'(RES_DEPTH)) || pop_ok;
	assign cmd_take = cmd_valid && room;
	assign res_wr   = cmd_take && emit;

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		base_d  = base_q;
		mag_d   = mag_q;
		ovf_d   = ovf_q;
		cnt_d   = cnt_q;
		pend_d  = pend_q;
		done    = 1'b0;
		emit    = 1'b0;
		over    = 1'b0;
		thresh  = '0;
		prod    = '0;
		sum     = '0;
		res_d   = '{value: '0, count: '0, status: ST_OK};

		if (cmd.start) begin
			if (base_bad) begin
				phase_d      = PH_IDLE;
				emit         = 1'b1;
				res_d.status = ST_BAD_BASE;
				done         = 1'b1;
			end else begin
				phase_d = PH_LEAD;
				neg_d   = 1'b0;
				base_d  = cfg_base;
				mag_d   = '0;
				ovf_d   = 1'b0;
				cnt_d   = '0;
				pend_d  = 1'b1;
			end
		end

		if (!done && phase_d == PH_IDLE) begin
			done = 1'b1;
		end

		// leading whitespace and sign
		if (!done && phase_d == PH_LEAD) begin
			if (cmd.space) begin
				cnt_d = sat_inc(cnt_d);
				done  = 1'b1;
			end else begin
				phase_d = PH_DIGITS;
				if (cmd.minus || cmd.plus) begin
					neg_d = neg_d | cmd.minus;
					cnt_d = sat_inc(cnt_d);
					done  = 1'b1;
				end
			end
		end else if (!done && phase_d == PH_ZERO) begin
			// byte after a leading zero
			phase_d = PH_DIGITS;
			if (cmd.hex_mark) begin
				base_d = BASE_HEX;
				cnt_d  = sat_inc(cnt_d);
				done   = 1'b1;
			end else if (base_d == BASE_AUTO) begin
				base_d = BASE_OCT;
			end
		end

		// first byte of the number itself
		if (!done && pend_d) begin
			pend_d = 1'b0;
			if ((base_d == BASE_AUTO || base_d == BASE_HEX) && cmd.zero) begin
				cnt_d   = sat_inc(cnt_d);
				phase_d = PH_ZERO;
				done    = 1'b1;
			end else if (base_d == BASE_AUTO) begin
				base_d = BASE_DEC;
			end
		end

		if (!done) begin
			if (base_d < BASE_MIN || cmd.digit >= base_d) begin
				// end of the number
				over = ovf_d || (mag_d == MAX_MAG && !neg_d);
				emit = 1'b1;
				if (over) begin
					res_d.value  = neg_d ? MAX_MAG : MAX_MAG - 1'b1;
					res_d.status = ST_RANGE;
				end else begin
					res_d.value  = neg_d ? VALUE_BITS'(0) - mag_d : mag_d;
					res_d.status = ST_OK;
				end
				res_d.count = cnt_d;
				phase_d     = PH_IDLE;
			end else begin
				thresh = (base_d <= BASE_TOP) ? THRESH_TABLE[base_d] : '0;
				prod   = PROD_BITS'(mag_d) * PROD_BITS'(base_d);
				sum    = (VALUE_BITS+1)'(prod[VALUE_BITS-1:0]) + (VALUE_BITS+1)'(cmd.digit);
				if (mag_d <= thresh) begin
					if (sum <= (VALUE_BITS+1)'(MAX_MAG)) begin
						mag_d = sum[VALUE_BITS-1:0];
					end else begin
						mag_d = prod[VALUE_BITS-1:0];
						ovf_d = 1'b1;
					end
				end else begin
					ovf_d = 1'b1;
				end
				cnt_d = sat_inc(cnt_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else if (cmd_take) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			mag_q   <= mag_d;
			ovf_q   <= ovf_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	// result queue
	assign res_value  = res_q[res_rd_ptr_q].value;
	assign res_count  = res_q[res_rd_ptr_q].count;
	assign res_status = res_q[res_rd_ptr_q].status;

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q[res_wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= '0;
			res_rd_ptr_q <= '0;
			res_cnt_q    <= '0;
		end else begin
			if (res_wr) begin
				res_wr_ptr_q <= (res_wr_ptr_q == RES_PTR_BITS'(RES_DEPTH - 1)) ?
					'0 : res_wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				res_rd_ptr_q <= (res_rd_ptr_q == RES_PTR_BITS'(RES_DEPTH - 1)) ?
					'0 : res_rd_ptr_q + 1'b1;
			end
			if (res_wr && !pop_ok) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (pop_ok && !res_wr) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	a_bad_base_reports: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.start && base_bad |=> phase_q == PH_IDLE && res_cnt_q != '0)
		else $error("invalid base start did not report and go idle");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !(cmd_take && cmd.start) |=> ovf_q)
		else $error("overflow flag dropped within a parse");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_take && cmd.start) |=> cnt_q >= $past(cnt_q))
		else $error("consumed count went down within a parse");

endmodule

// ===== bench/tb_string_to_integer_parser.sv =====
module tb_string_to_integer_parser;

	timeunit 1ns;
	timeprecision 1ps;

	import stip_pkg::*;

	// cycles with no accepted request before the run is declared hung
	localparam int STALL_LIMIT   = 3000;
	// quiet cycles before a base write and after the last result
	localparam int SETTLE_CYCLES = 8;
	// length of the one long receiver hold-off
	localparam int HOLD_CYCLES   = 300;
	// live input bytes wanted over the whole run, and per base setting
	localparam int TOTAL_BYTES   = 1950;
	localparam int PHASE_BYTES   = 240;

	localparam logic [CHAR_BITS-1:0] CH_NUL = 8'h00;
	localparam logic [63:0] MAGNITUDE_LIMIT = 64'd1 << (VALUE_BITS - 1);

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_LEAD,
		SCAN_ZERO,
		SCAN_DIGITS
	} scan_phase_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_BASE
	} row_kind_t;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
		status_t               status;
	} parse_result_t;

	// one row of the directed table: a base write or one byte request,
	// with a hand-typed result where it is obvious
	typedef struct packed {
		row_kind_t             kind;
		logic [BASE_BITS-1:0]  base;
		logic                  start;
		logic [CHAR_BITS-1:0]  ch;
		logic                  typed;
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] count;
		status_t               status;
	} directed_row_t;

	localparam directed_row_t DIRECTED_ROWS [29] = '{
		// reset base 10: whitespace, plus sign, one digit, nul ends
		'{ROW_BYTE, 6'd0,  1'b1, CH_TAB,   1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "+",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "7",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, CH_NUL,   1'b1, 32'd7,         16'd3, ST_OK},
		// byte without start while idle, dropped silently
		'{ROW_BYTE, 6'd0,  1'b0, 8'hFF,    1'b0, 32'd0,         16'd0, ST_OK},
		// invalid bases report at once
		'{ROW_BASE, 6'd1,  1'b0, CH_NUL,   1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b1, "x",      1'b1, 32'd0,         16'd0, ST_BAD_BASE},
		'{ROW_BASE, 6'd63, 1'b0, CH_NUL,   1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b1, "5",      1'b1, 32'd0,         16'd0, ST_BAD_BASE},
		// base 36: -zik0zk is exactly the most negative value
		'{ROW_BASE, 6'd36, 1'b0, CH_NUL,   1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b1, "-",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "z",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "i",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "k",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "0",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "z",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "k",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, ".",      1'b1, 32'h8000_0000, 16'd7, ST_OK},
		// same magnitude positive is out of range and saturates high
		'{ROW_BYTE, 6'd0,  1'b1, "Z",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "I",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "K",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "0",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "Z",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "K",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "!",      1'b1, 32'h7FFF_FFFF, 16'd6, ST_RANGE},
		// auto base: 0x with no hex digit still counts the prefix
		'{ROW_BASE, 6'd0,  1'b0, CH_NUL,   1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b1, "0",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "x",      1'b0, 32'd0,         16'd0, ST_OK},
		'{ROW_BYTE, 6'd0,  1'b0, "g",      1'b1, 32'd0,         16'd2, ST_OK}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [BASE_BITS-1:0] number_base;
	logic push;
	logic full;
	logic start_flag;
	logic [CHAR_BITS-1:0] char_code;
	logic empty;
	logic pop = 1'b0;
	logic signed [VALUE_BITS-1:0] parsed_value;
	logic [COUNT_BITS-1:0] consumed_count;
	logic [STATUS_BITS-1:0] parse_status;

	string_to_integer_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.number_base    (number_base),
		.push           (push),
		.full           (full),
		.start_flag     (start_flag),
		.char_code      (char_code),
		.empty          (empty),
		.pop            (pop),
		.parsed_value   (parsed_value),
		.consumed_count (consumed_count),
		.parse_status   (parse_status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the parser: base register and per-string scan state
	logic [BASE_BITS-1:0]  base_reg;
	scan_phase_t           scan_phase;
	logic                  negative;
	logic [BASE_BITS-1:0]  radix;
	logic [63:0]           magnitude;
	logic                  overflowed;
	logic [COUNT_BITS-1:0] consumed;
	logic                  prefix_due;

	// results still owed by the block, oldest first
	parse_result_t pending_numbers [$];

	int fail_count = 0;
	int live_bytes = 0;
	logic pressure_go = 1'b0;

	function automatic int unsigned digit_value(input logic [CHAR_BITS-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return c - CH_ZERO;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			return c - CH_UP_A + 10;
		if (c >= CH_LOW_A && c <= CH_LOW_Z)
			return c - CH_LOW_A + 10;
		return DIGIT_NONE;
	endfunction

	// byte counter saturates at its top value
	function automatic void count_byte();
		if (consumed != '1)
			consumed = consumed + 1'b1;
	endfunction

	// advance the shadow by one byte; returns 1 when the byte ends a string
	function automatic bit scan_char(input logic s, input logic [CHAR_BITS-1:0] c,
			output parse_result_t r);
		int unsigned d;
		logic [63:0] thresh;
		r.value = '0;
		r.count = '0;
		r.status = ST_OK;
		if (s) begin
			if (base_reg == BASE_UNARY || base_reg > MAX_BASE) begin
				scan_phase = SCAN_IDLE;
				r.status = ST_BAD_BASE;
				return 1'b1;
			end
			scan_phase = SCAN_LEAD;
			negative = 1'b0;
			radix = base_reg;
			magnitude = '0;
			overflowed = 1'b0;
			consumed = '0;
			prefix_due = 1'b1;
		end
		if (scan_phase == SCAN_IDLE)
			return 1'b0;
		if (scan_phase == SCAN_LEAD) begin
			if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
				count_byte();
				return 1'b0;
			end
			scan_phase = SCAN_DIGITS;
			if (c == CH_MINUS || c == CH_PLUS) begin
				negative = (c == CH_MINUS);
				count_byte();
				return 1'b0;
			end
		end else if (scan_phase == SCAN_ZERO) begin
			// the byte after a leading zero decides hex or octal
			scan_phase = SCAN_DIGITS;
			if (c == CH_LOW_X || c == CH_UP_X) begin
				radix = BASE_HEX;
				count_byte();
				return 1'b0;
			end
			if (radix == BASE_AUTO)
				radix = BASE_OCT;
		end
		if (prefix_due) begin
			prefix_due = 1'b0;
			if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
				count_byte();
				scan_phase = SCAN_ZERO;
				return 1'b0;
			end
			if (radix == BASE_AUTO)
				radix = BASE_DEC;
		end
		d = digit_value(c);
		if (d >= radix) begin
			// first non-digit: emit the result and go idle
			scan_phase = SCAN_IDLE;
			if (overflowed || (magnitude == MAGNITUDE_LIMIT && !negative)) begin
				r.status = ST_RANGE;
				r.value = negative ? VALUE_BITS'(MAGNITUDE_LIMIT)
					: VALUE_BITS'(MAGNITUDE_LIMIT - 1);
			end else begin
				r.value = negative ? VALUE_BITS'(64'd0 - magnitude) : VALUE_BITS'(magnitude);
			end
			r.count = consumed;
			return 1'b1;
		end
		thresh = MAGNITUDE_LIMIT / radix;
		if (magnitude <= thresh) begin
			magnitude = magnitude * radix;
			if (magnitude <= MAGNITUDE_LIMIT - d)
				magnitude = magnitude + d;
			else
				overflowed = 1'b1;
		end else begin
			overflowed = 1'b1;
		end
		count_byte();
		return 1'b0;
	endfunction

	// offer one byte request, idling at random before it, and hold it
	// until the block takes it; the expected result is queued on acceptance
	task automatic push_byte(input logic s, input logic [CHAR_BITS-1:0] c, input logic typed,
			input parse_result_t typed_result);
		parse_result_t predicted;
		bit ignored;
		bit ends;
		// no sender idling over one long stretch of the run
		while (!(live_bytes >= 900 && live_bytes < 1200) && $urandom_range(0, 99) < 25) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		start_flag <= s;
		char_code <= c;
		do @(posedge clk); while (full);
		ignored = !s && scan_phase == SCAN_IDLE;
		ends = scan_char(s, c, predicted);
		if (!ignored)
			live_bytes++;
		if (ends)
			pending_numbers.push_back(typed ? typed_result : predicted);
	endtask

	// base writes only once every result is out and the byte queue is drained
	task automatic write_base(input logic [BASE_BITS-1:0] b);
		push <= 1'b0;
		while (pending_numbers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		number_base <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_reg = b;
	endtask

	// result side: check every popped request, idle at random, one long hold-off
	always @(posedge clk) begin : result_checker
		parse_result_t want;
		static int results_seen = 0;
		static int hold_left = 0;
		static bit hold_done = 1'b0;
		if (pop && !empty) begin
			results_seen++;
			if (pending_numbers.size() == 0) begin
				$error("result with no expectation pending: value %0d count %0d status %0d",
					parsed_value, consumed_count, parse_status);
				fail_count++;
			end else begin
				want = pending_numbers.pop_front();
				if (parsed_value !== want.value) begin
					$error("parsed_value: expected %0d, actual %0d",
						$signed(want.value), parsed_value);
					fail_count++;
				end
				if (consumed_count !== want.count) begin
					$error("consumed_count: expected %0d, actual %0d",
						want.count, consumed_count);
					fail_count++;
				end
				if (parse_status !== want.status) begin
					$error("parse_status: expected %0d, actual %0d",
						want.status, parse_status);
					fail_count++;
				end
			end
		end
		// the long hold-off lets the result queue and the byte queue fill
		if (hold_left != 0) begin
			hold_left--;
		end else if (pressure_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		pop <= arst_n && hold_left == 0
			&& ((results_seen >= 60 && results_seen < 120) || $urandom_range(0, 99) >= 25);
	end

	// ends the run when no request of any kind moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		directed_row_t row;
		parse_result_t typed_result;
		logic [CHAR_BITS-1:0] text [$];
		logic [CHAR_BITS-1:0] ch;
		logic [BASE_BITS-1:0] phase_base;
		logic [63:0] reach;
		int phase_no;
		int phase_start;
		int kind;
		int r;
		int eb;
		int span;
		int d;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		number_base = BASE_RESET;
		push = 1'b0;
		start_flag = 1'b0;
		char_code = CH_NUL;

		base_reg = BASE_RESET;
		scan_phase = SCAN_IDLE;
		negative = 1'b0;
		radix = '0;
		magnitude = '0;
		overflowed = 1'b0;
		consumed = '0;
		prefix_due = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_BASE) begin
				write_base(row.base);
			end else begin
				typed_result.value = row.value;
				typed_result.count = row.count;
				typed_result.status = row.status;
				push_byte(row.start, row.ch, row.typed, typed_result);
			end
		end

		// random strings, one base setting per phase
		phase_no = 0;
		while (live_bytes < TOTAL_BYTES) begin
			case (phase_no % 8)
				0: phase_base = BASE_AUTO;
				1: phase_base = BASE_HEX;
				2: phase_base = BASE_OCT;
				3: phase_base = BASE_MIN;
				4: phase_base = BASE_TOP;
				5: phase_base = BASE_DEC;
				6: phase_base = BASE_BITS'($urandom_range(2, MAX_BASE));
				default: phase_base = BASE_BITS'($urandom_range(0, 63));
			endcase
			write_base(phase_base);
			phase_start = live_bytes;
			while (live_bytes - phase_start < PHASE_BYTES && live_bytes < TOTAL_BYTES) begin
				kind = $urandom_range(0, 99);
				text.delete();
				if (kind < 12) begin
					// noise: raw bytes with a random start flag
					repeat ($urandom_range(1, 6))
						push_byte($urandom_range(0, 3) == 0, CHAR_BITS'($urandom_range(0, 255)),
							1'b0, typed_result);
				end else begin
					repeat ($urandom_range(0, 2)) begin
						r = $urandom_range(0, 5);
						text.push_back(r == 5 ? CH_SPACE : CHAR_BITS'(CH_TAB + r));
					end
					r = $urandom_range(0, 2);
					if (r == 1)
						text.push_back(CH_PLUS);
					else if (r == 2)
						text.push_back(CH_MINUS);
					// prefix and the radix the digits are drawn in
					r = $urandom_range(0, 2);
					if (phase_base == BASE_AUTO) begin
						if (r != 2)
							text.push_back(CH_ZERO);
						if (r == 0)
							text.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
						eb = (r == 0) ? 16 : (r == 1) ? 8 : 10;
					end else if (phase_base == BASE_HEX) begin
						if (r == 0) begin
							text.push_back(CH_ZERO);
							text.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
						end
						eb = 16;
					end else if (phase_base == BASE_UNARY || phase_base > MAX_BASE) begin
						eb = 10;
					end else begin
						eb = phase_base;
					end
					// digits up to a couple past what fills the magnitude
					reach = 64'd1;
					span = 0;
					while (reach <= MAGNITUDE_LIMIT) begin
						reach = reach * eb;
						span++;
					end
					repeat ($urandom_range(0, span + 2)) begin
						d = $urandom_range(0, eb - 1);
						if (d < 10)
							text.push_back(CHAR_BITS'(CH_ZERO + d));
						else
							text.push_back(CHAR_BITS'(($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A)
								+ d - 10));
					end
					ch = ($urandom_range(0, 3) == 0) ? CH_NUL : CHAR_BITS'($urandom_range(0, 255));
					if (digit_value(ch) < eb)
						ch = CH_NUL;
					text.push_back(ch);
					// broken strings: no end byte, or one byte garbled
					if (kind < 20 && text.size() > 1) begin
						if ($urandom_range(0, 1))
							void'(text.pop_back());
						else
							text[$urandom_range(0, text.size() - 1)] =
								CHAR_BITS'($urandom_range(0, 255));
					end
					foreach (text[i])
						push_byte(i == 0, text[i], 1'b0, typed_result);
				end
				if (!pressure_go && live_bytes >= 400)
					pressure_go <= 1'b1;
			end
			// a nul closes whatever string is still open
			push_byte(1'b0, CH_NUL, 1'b0, typed_result);
			phase_no++;
		end

		push <= 1'b0;
		while (pending_numbers.size() != 0)
			@(negedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
